/* src/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the shellsort record sorter
// record layout, sequencer states, gap arithmetic and comparison counter limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srs_pkg;

  // field widths
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned CMP_W    = 16;

  // gap register width, wide enough for the largest knuth gap at a batch of 64
  localparam int unsigned H_W      = 7;

  // h / 3 as (h * 43) >> 7, exact for every h below 128
  localparam int unsigned DIV3_MUL = 43;
  localparam int unsigned DIV3_SH  = 7;
  localparam int unsigned PROD_W   = 14;

  // comparison counter
  localparam logic [CMP_W-1:0] CMP_STEP = 16'd3;
  localparam logic [CMP_W-1:0] CMP_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
    logic [KEY_W-1:0]    key;
  } srs_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_PASS,
    S_ITER,
    S_TAKE,
    S_CMP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT
  } srs_state_e;

  // true when record a belongs after record b
  function automatic logic goes_after(srs_rec_t a, srs_rec_t b);
    goes_after = (a.weight > b.weight) || ((a.weight == b.weight) && (a.key > b.key));
  endfunction

endpackage

/* src/srs_store.sv */
// ----------------------------------------------------------------------------
// srs_store: record memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  srs_pkg::srs_rec_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output srs_pkg::srs_rec_t rdata_o
);
  import srs_pkg::*;

  srs_rec_t mem [DEPTH];
  srs_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/shellsort_record_sorter.sv */
// ----------------------------------------------------------------------------
// shellsort_record_sorter: batch record sorter, shellsort with knuth gaps
// loads records until one marked last, sorts by weight then name key, emits all
// ----------------------------------------------------------------------------
// load: one record per cycle, busy stays low while records arrive
// sort: h grows in knuth steps, then each pass runs on h / 3, every element taken
//   compared and shifted (one pass per knuth gap below the count, at least one)
// every step goes through the record memory, one write and one read port with registered read
// emit: one result beat per cycle, the receiver cannot stall
// reset clears the sequencer, record count and comparison count; memory holds junk
`timescale 1ns / 1ps

module shellsort_record_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [srs_pkg::TAG_W-1:0]     record_tag_i,
  input  logic [srs_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic [srs_pkg::KEY_W-1:0]     name_key_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  output logic [srs_pkg::TAG_W-1:0]     out_tag_o,
  output logic [srs_pkg::WEIGHT_W-1:0]  out_weight_o,
  output logic [srs_pkg::KEY_W-1:0]     out_name_key_o,
  output logic [srs_pkg::CMP_W-1:0]     comparison_count_o,
  output logic                          last_out_o
);
  import srs_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // sequencer state
  srs_state_e       state_q, state_d;
  logic [H_W-1:0]   h_q, h_d;          // current gap
  logic [CW-1:0]    i_q, i_d;          // element taken, or emit position
  logic [CW-1:0]    pos_q, pos_d;      // hole of the running insertion
  logic [CW-1:0]    cnt_q, cnt_d;      // records held
  logic [CMP_W-1:0] cmp_q, cmp_d;      // comparison count
  srs_rec_t         temp_q, temp_d;    // record being inserted

  // memory port
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  srs_rec_t       mem_wdata;
  srs_rec_t       mem_rdata;
  srs_rec_t       in_rec;

  // shared arithmetic
  logic [H_W-1:0]    h_grow;     // 3h + 1
  logic [PROD_W-1:0] h_prod;
  logic [H_W-1:0]    h_third;    // h / 3
  logic [H_W-1:0]    i_minus_h;
  logic [H_W-1:0]    pos_minus_h;
  logic [H_W-1:0]    pos_minus_2h;
  logic [CMP_W-1:0]  cmp_sat;
  logic              emit_last;

  assign in_rec = '{tag: record_tag_i, weight: weight_i, key: name_key_i};

  assign h_grow       = H_W'({h_q, 1'b0} + h_q + 1'b1);
  assign h_prod       = PROD_W'(h_q) * PROD_W'(DIV3_MUL);
  assign h_third      = h_prod[DIV3_SH +: H_W];
  assign i_minus_h    = H_W'(i_q) - h_q;
  assign pos_minus_h  = H_W'(pos_q) - h_q;
  assign pos_minus_2h = pos_minus_h - h_q;
  assign cmp_sat      = (cmp_q > (CMP_MAX - CMP_STEP)) ? CMP_MAX : cmp_q + CMP_STEP;
  assign emit_last    = (i_q == (cnt_q - CW'(1)));

  srs_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      h_q     <= '0;
      i_q     <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      i_q     <= i_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    i_d       = i_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    cmp_d     = cmp_q;
    temp_d    = temp_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = in_rec;
    mem_raddr = i_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          // records past capacity are dropped, a dropped last still sorts
          if (cnt_q < CAP_C) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
          if (last_in_i) begin
            cmp_d   = '0;
            h_d     = H_W'(1);
            state_d = S_GAP;
          end
        end
      end

      S_GAP: begin
        // grow h = 3h + 1 at least once and while below the count
        h_d = h_grow;
        if (h_grow >= H_W'(cnt_q)) begin
          state_d = S_PASS;
        end
      end

      S_PASS: begin
        h_d     = h_third;
        i_d     = CW'(h_third);
        state_d = S_ITER;
      end

      S_ITER: begin
        if (i_q >= cnt_q) begin
          if (h_q == H_W'(1)) begin
            i_d     = '0;
            state_d = S_EMIT_RD;
          end else begin
            state_d = S_PASS;
          end
        end else begin
          mem_raddr = i_q[AW-1:0];
          state_d   = S_TAKE;
        end
      end

      S_TAKE: begin
        // element i taken, first neighbor read at i - h
        temp_d    = mem_rdata;
        pos_d     = i_q;
        cmp_d     = cmp_sat;
        mem_raddr = i_minus_h[AW-1:0];
        state_d   = S_CMP;
      end

      S_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        if (goes_after(mem_rdata, temp_q)) begin
          // shift the neighbor up into the hole
          mem_wdata = mem_rdata;
          pos_d     = CW'(pos_minus_h);
          cmp_d     = cmp_sat;
          if (pos_minus_h >= h_q) begin
            mem_raddr = pos_minus_2h[AW-1:0];
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          mem_wdata = temp_q;
          i_d       = i_q + CW'(1);
          state_d   = S_ITER;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = temp_q;
        i_d       = i_q + CW'(1);
        state_d   = S_ITER;
      end

      S_EMIT_RD: begin
        mem_raddr = i_q[AW-1:0];
        state_d   = S_EMIT;
      end

      S_EMIT: begin
        // prefetch next position while this beat goes out
        mem_raddr = AW'(i_q + CW'(1));
        i_d       = i_q + CW'(1);
        if (emit_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy               = (state_q != S_IDLE);
  assign out_valid_o        = (state_q == S_EMIT);
  assign out_tag_o          = mem_rdata.tag;
  assign out_weight_o       = mem_rdata.weight;
  assign out_name_key_o     = mem_rdata.key;
  assign comparison_count_o = cmp_q;
  assign last_out_o         = out_valid_o && emit_last;

  // a result beat only comes out of a running batch
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result beat while idle");

  // the hole always has a neighbor one gap below when compared
  a_cmp_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (H_W'(pos_q) >= h_q))
    else $error("compare without a neighbor below");

  // comparison count only grows during a sort
  a_cmp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && $past(state_q != S_IDLE)) |-> (cmp_q >= $past(cmp_q)))
    else $error("comparison count went down");

  // the last beat ends the batch
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |=> (!busy && (cnt_q == '0)))
    else $error("batch not closed after last beat");

  // emission never runs past the held records
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_q < cnt_q))
    else $error("emit position beyond record count");

endmodule
